FILE: rtl/core/kfl_pkg.sv
// Shared constants and types for the keyframe loop candidate search.
`default_nettype none

package kfl_pkg;

  localparam int unsigned MAX_KEYFRAMES = 1024;
  localparam int unsigned SLOT_W        = $clog2(MAX_KEYFRAMES);
  localparam int unsigned CNT_W         = $clog2(MAX_KEYFRAMES + 1);

  localparam int unsigned POS_W     = 24;
  localparam int unsigned STAMP_W   = 32;
  localparam int unsigned DIST_W    = 23;
  localparam int unsigned DIFF_W    = POS_W + 1;
  localparam int unsigned SQ_W      = 2 * POS_W;
  localparam int unsigned D2_W      = SQ_W + 2;
  localparam int unsigned THR2_W    = 2 * DIST_W;
  localparam int unsigned OUT_SLOT_W = 10;

  localparam int unsigned IN_DATA_W  = 104;
  localparam int unsigned OUT_DATA_W = 24;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_KF_DIST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_RAD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_GAP = 2'd2;

  localparam logic [DIST_W-1:0]  KF_DIST_RST  = 23'd1000;
  localparam logic [DIST_W-1:0]  LOOP_RAD_RST = 23'd7000;
  localparam logic [STAMP_W-1:0] LOOP_GAP_RST = 32'd20000;

  // One stored keyframe; x sits in the lowest bits, same as the input tdata.
  typedef struct packed {
    logic [STAMP_W-1:0]      stamp;
    logic signed [POS_W-1:0] z;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] x;
  } kf_entry_t;

  typedef struct packed {
    logic            valid;
    logic [D2_W-1:0] d2;
    logic            gap_ok;
  } dist_res_t;

endpackage

`default_nettype wire

FILE: rtl/core/kfl_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module kfl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/kfl_sqdist.sv
// Three-stage squared distance and stamp gap unit.
`default_nettype none

module kfl_sqdist (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              valid_i,
  input  wire kfl_pkg::kf_entry_t                key_i,
  input  wire kfl_pkg::kf_entry_t                pose_i,
  input  wire logic [kfl_pkg::STAMP_W-1:0]       min_gap_i,
  output kfl_pkg::dist_res_t                     res_o,
  output logic                                   busy_o
);
  import kfl_pkg::*;

  // stage A: differences
  logic                     va_q;
  logic signed [DIFF_W-1:0] dx_q, dy_q, dz_q;
  logic [STAMP_W:0]         sdiff_q;
  // stage B: squares
  logic                     vb_q;
  logic [SQ_W-1:0]          sqx_q, sqy_q, sqz_q;
  logic                     gap_b_q;
  // stage C: sum
  logic                     vc_q;
  logic [D2_W-1:0]          d2_q;
  logic                     gap_c_q;

  logic signed [2*DIFF_W-1:0] px, py, pz;
  logic                       gap_ok;

  assign px = dx_q * dx_q;
  assign py = dy_q * dy_q;
  assign pz = dz_q * dz_q;
  // stamp going backwards gives a negative difference, never above the gap
  assign gap_ok = $signed(sdiff_q) > $signed({1'b0, min_gap_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q    <= {key_i.x[POS_W-1], key_i.x} - {pose_i.x[POS_W-1], pose_i.x};
    dy_q    <= {key_i.y[POS_W-1], key_i.y} - {pose_i.y[POS_W-1], pose_i.y};
    dz_q    <= {key_i.z[POS_W-1], key_i.z} - {pose_i.z[POS_W-1], pose_i.z};
    sdiff_q <= {1'b0, pose_i.stamp} - {1'b0, key_i.stamp};
    sqx_q   <= px[SQ_W-1:0];
    sqy_q   <= py[SQ_W-1:0];
    sqz_q   <= pz[SQ_W-1:0];
    gap_b_q <= gap_ok;
    d2_q    <= D2_W'(sqx_q) + D2_W'(sqy_q) + D2_W'(sqz_q);
    gap_c_q <= gap_b_q;
  end

  assign res_o.valid  = vc_q;
  assign res_o.d2     = d2_q;
  assign res_o.gap_ok = gap_c_q;
  assign busy_o       = va_q | vb_q | vc_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) valid_i |-> ##3 res_o.valid)
    else $error("distance result lost in pipeline");
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_o.valid |-> $past(busy_o))
    else $error("distance result without work in flight");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   res_o.valid |-> d2_q[D2_W-1:D2_W-2] != 2'b11)
    else $error("squared distance above three full squares");

endmodule

`default_nettype wire

FILE: rtl/core/keyframe_loop_candidate_search.sv
// Keyframe selection and loop candidate scan over a keyframe memory.
// Flow: a pose that is not a keyframe is settled by one read of the newest stored keyframe,
//   one dropped on a full store passes through COMMIT as well; a new keyframe scans all older
//   entries, with one read per stored keyframe from the single RAM port.
// Throughput: one pose at a time; the next request is taken only once the result is
//   registered, after the whole scan of the previous pose, plus any output stall.
// Reset: registers return to 1000 / 7000 / 20000 and the store count to zero;
//   memory contents are not cleared, only entries below the count are read.
`default_nettype none

module keyframe_loop_candidate_search (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // tdata: pos_x[23:0], pos_y[47:24], pos_z[71:48], stamp_ms[103:72]
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [kfl_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // tdata: became_keyframe[0], keyframe_slot[10:1], loop_found[11],
  //        loop_slot[21:12], store_full[22], zero[23]
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [kfl_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
  input  wire logic                              cfg_we_i,
  input  wire logic [kfl_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [kfl_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import kfl_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_QUAL   = 3'd1;
  localparam logic [2:0] ST_COMMIT = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_DRAIN  = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [DIST_W-1:0]  kf_dist_q, loop_rad_q;
  logic [STAMP_W-1:0] loop_gap_q;
  logic [THR2_W-1:0]  thr2_q, r2_q;

  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   n_q, n_d;
  logic [SLOT_W-1:0]  rd_idx_q, rd_idx_d;
  logic [SLOT_W-1:0]  res_idx_q, res_idx_d;
  kf_entry_t          pose_q;

  logic               became_q, became_d;
  logic               full_q, full_d;
  logic               found_q, found_d;
  logic [SLOT_W-1:0]  best_idx_q, best_idx_d;
  logic [D2_W-1:0]    best_q, best_d;

  logic               out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  logic               accept;
  logic               rd_en, wr_en;
  logic [SLOT_W-1:0]  rd_addr;
  logic               ram_valid_q;
  kf_entry_t          ram_rdata;
  dist_res_t          dres;
  logic               dist_busy;
  logic               hit;
  logic [CNT_W-1:0]   newest;
  logic [OUT_SLOT_W-1:0] kf_slot_out, loop_slot_out;
  logic               scanning;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign scanning      = (state_q == ST_SCAN) || (state_q == ST_DRAIN);

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kf_dist_q  <= KF_DIST_RST;
      loop_rad_q <= LOOP_RAD_RST;
      loop_gap_q <= LOOP_GAP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_KF_DIST:  kf_dist_q  <= cfg_data_i[DIST_W-1:0];
        CFG_LOOP_RAD: loop_rad_q <= cfg_data_i[DIST_W-1:0];
        CFG_LOOP_GAP: loop_gap_q <= cfg_data_i[STAMP_W-1:0];
        default: ;
      endcase
    end
  end

  // squared thresholds follow the registers in the next cycle
  always_ff @(posedge clk_i) begin
    thr2_q <= THR2_W'(kf_dist_q) * THR2_W'(kf_dist_q);
    r2_q   <= THR2_W'(loop_rad_q) * THR2_W'(loop_rad_q);
  end

  assign rd_en   = (accept && count_q != '0) || (state_q == ST_SCAN);
  assign rd_addr = (state_q == ST_SCAN) ? rd_idx_q : SLOT_W'(count_q - 1'b1);
  assign wr_en   = (state_q == ST_COMMIT) && (count_q != CNT_W'(MAX_KEYFRAMES));

  kfl_ram #(
    .WIDTH ($bits(kf_entry_t)),
    .DEPTH (MAX_KEYFRAMES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (count_q[SLOT_W-1:0]),
    .wdata_i (pose_q),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  kfl_sqdist u_dist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (ram_valid_q),
    .key_i     (ram_rdata),
    .pose_i    (pose_q),
    .min_gap_i (loop_gap_q),
    .res_o     (dres),
    .busy_o    (dist_busy)
  );

  assign hit = dres.valid && dres.gap_ok && (dres.d2 < D2_W'(r2_q)) &&
               (!found_q || dres.d2 < best_q);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    n_d        = n_q;
    rd_idx_d   = rd_idx_q;
    res_idx_d  = res_idx_q;
    became_d   = became_q;
    full_d     = full_q;
    found_d    = found_q;
    best_idx_d = best_idx_q;
    best_d     = best_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          became_d   = 1'b0;
          full_d     = 1'b0;
          found_d    = 1'b0;
          best_idx_d = '0;
          state_d    = (count_q == '0) ? ST_COMMIT : ST_QUAL;
        end
      end
      ST_QUAL: begin
        if (dres.valid) begin
          state_d = (dres.d2 > D2_W'(thr2_q)) ? ST_COMMIT : ST_DONE;
        end
      end
      ST_COMMIT: begin
        if (count_q == CNT_W'(MAX_KEYFRAMES)) begin
          full_d  = 1'b1;
          state_d = ST_DONE;
        end else begin
          became_d  = 1'b1;
          count_d   = count_q + 1'b1;
          n_d       = count_q;
          rd_idx_d  = '0;
          res_idx_d = '0;
          state_d   = (count_q == '0) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_idx_d = rd_idx_q + 1'b1;
        if (CNT_W'(rd_idx_q) + 1'b1 == n_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!ram_valid_q && !dist_busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    // results come back in scan order, so a counter names their slot
    if (scanning && dres.valid) begin
      res_idx_d = res_idx_q + 1'b1;
      if (hit) begin
        found_d    = 1'b1;
        best_d     = dres.d2;
        best_idx_d = res_idx_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      n_q         <= '0;
      rd_idx_q    <= '0;
      res_idx_q   <= '0;
      became_q    <= 1'b0;
      full_q      <= 1'b0;
      found_q     <= 1'b0;
      best_idx_q  <= '0;
      ram_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      n_q         <= n_d;
      rd_idx_q    <= rd_idx_d;
      res_idx_q   <= res_idx_d;
      became_q    <= became_d;
      full_q      <= full_d;
      found_q     <= found_d;
      best_idx_q  <= best_idx_d;
      ram_valid_q <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    if (accept) begin
      pose_q <= kf_entry_t'(s_axis_tdata);
    end
  end

  // output register
  assign newest        = count_q - 1'b1;
  assign kf_slot_out   = OUT_SLOT_W'(newest);
  assign loop_slot_out = found_q ? OUT_SLOT_W'(best_idx_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && (!out_valid_q || m_axis_tready)) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && (!out_valid_q || m_axis_tready)) begin
      out_data_q <= {1'b0, full_q, loop_slot_out, found_q, kf_slot_out, became_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (wr_en && rd_en) |-> (count_q[SLOT_W-1:0] != rd_addr))
    else $error("store read and write hit the same entry");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   count_q <= CNT_W'(MAX_KEYFRAMES))
    else $error("keyframe count beyond store depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == ST_SCAN) |-> (CNT_W'(rd_idx_q) < n_q))
    else $error("scan reads at or past the new keyframe");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == ST_DONE) |-> !(found_q && !became_q) && !(full_q && became_q))
    else $error("inconsistent result flags");

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// Stream testbench for the keyframe loop candidate search, with an in-bench scoreboard.
`timescale 1ns / 100ps

module testbench;
  import kfl_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // unmapped index, writes are dropped

  typedef struct packed {
    logic                  store_full;
    logic [OUT_SLOT_W-1:0] loop_slot;
    logic                  loop_found;
    logic [OUT_SLOT_W-1:0] keyframe_slot;
    logic                  became_keyframe;
  } outcome_t;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_SPARSE} rx_mode_e;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  // tdata: pos_x[23:0], pos_y[47:24], pos_z[71:48], stamp_ms[103:72]
  logic [IN_DATA_W-1:0]    s_axis_tdata = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  // tdata: became_keyframe[0], keyframe_slot[10:1], loop_found[11],
  //        loop_slot[21:12], store_full[22], zero[23]
  logic [OUT_DATA_W-1:0]   m_axis_tdata;
  logic                    cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_i = '0;

  keyframe_loop_candidate_search DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Mirror of the block: thresholds and the keyframe store.
  logic [DIST_W-1:0]  thr_dist = KF_DIST_RST;
  logic [DIST_W-1:0]  radius   = LOOP_RAD_RST;
  logic [STAMP_W-1:0] min_gap  = LOOP_GAP_RST;
  kf_entry_t          kf_store [MAX_KEYFRAMES];
  int                 kf_total = 0;

  kf_entry_t poses_to_send [$];
  outcome_t  outcomes_due [$];
  int        bad_outcomes = 0;
  int        checked = 0;

  // Trajectory generator state.
  logic signed [POS_W-1:0] walk_x = '0, walk_y = '0, walk_z = '0;
  logic [STAMP_W-1:0]      walk_t = 32'd300000;
  kf_entry_t               trail [$];

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #16_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic longint sq_span(kf_entry_t a, kf_entry_t b);
    longint dx, dy, dz;
    dx = longint'($signed(a.x)) - longint'($signed(b.x));
    dy = longint'($signed(a.y)) - longint'($signed(b.y));
    dz = longint'($signed(a.z)) - longint'($signed(b.z));
    return dx * dx + dy * dy + dz * dz;
  endfunction

  // Keyframe decision plus nearest loop candidate; updates the mirrored store.
  function automatic outcome_t search_outcome(kf_entry_t p);
    outcome_t res;
    longint   d2, best, age, lim;
    bit       take;
    res = '0;
    best = 0;
    if (kf_total == 0) begin
      take = 1'b1;
    end else begin
      lim = longint'(thr_dist) * longint'(thr_dist);
      take = sq_span(kf_store[kf_total-1], p) > lim;
    end
    if (take && kf_total >= MAX_KEYFRAMES) begin
      res.store_full = 1'b1;
    end else if (take) begin
      lim = longint'(radius) * longint'(radius);
      for (int i = 0; i < kf_total; i++) begin
        d2 = sq_span(kf_store[i], p);
        // stamps compared as a signed difference, so going backwards never qualifies
        age = longint'(p.stamp) - longint'(kf_store[i].stamp);
        if (d2 < lim && age > longint'(min_gap) && (!res.loop_found || d2 < best)) begin
          res.loop_found = 1'b1;
          res.loop_slot  = i[OUT_SLOT_W-1:0];
          best = d2;
        end
      end
      kf_store[kf_total] = p;
      kf_total++;
      res.became_keyframe = 1'b1;
    end
    if (kf_total > 0) res.keyframe_slot = kf_total[OUT_SLOT_W-1:0] - 1'b1;
    return res;
  endfunction

  function automatic logic signed [POS_W-1:0] nudge(logic signed [POS_W-1:0] v, int span);
    int r;
    r = int'($urandom_range(2 * span)) - span;
    return v + r[POS_W-1:0];
  endfunction

  task automatic push_pose(input int x, input int y, input int z, input logic [31:0] t);
    kf_entry_t p;
    p.x = x[POS_W-1:0];
    p.y = y[POS_W-1:0];
    p.z = z[POS_W-1:0];
    p.stamp = t;
    poses_to_send.insert(poses_to_send.size(), p);
  endtask

  // Mostly a walk with forward time, some jumps back near old poses, some raw noise.
  task automatic push_walk(input int span, input int dt_max, input int revisit_pct,
                           input int noise_pct);
    kf_entry_t    p;
    logic [127:0] raw;
    int           pick;
    pick = $urandom_range(99);
    if (pick < noise_pct) begin
      raw = {$urandom(), $urandom(), $urandom(), $urandom()};
      p = raw[IN_DATA_W-1:0];
    end else begin
      if (pick < noise_pct + revisit_pct && trail.size() > 0) begin
        p = trail[$urandom_range(trail.size() - 1)];
        walk_x = nudge(p.x, span / 4);
        walk_y = nudge(p.y, span / 4);
        walk_z = nudge(p.z, span / 4);
      end else if (pick < 95) begin
        walk_x = nudge(walk_x, span);
        walk_y = nudge(walk_y, span);
        walk_z = nudge(walk_z, span);
      end
      walk_t += $urandom_range(dt_max);
      p.x = walk_x;
      p.y = walk_y;
      p.z = walk_z;
      p.stamp = walk_t;
      trail.insert(trail.size(), p);
    end
    poses_to_send.insert(poses_to_send.size(), p);
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (poses_to_send.size() != 0 || outcomes_due.size() != 0 || s_axis_tvalid);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_KF_DIST:  thr_dist = val[DIST_W-1:0];
      CFG_LOOP_RAD: radius   = val[DIST_W-1:0];
      CFG_LOOP_GAP: min_gap  = val;
      default: ;
    endcase
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset thresholds: 1000 / 7000 / 20000
    push_pose(0, 0, 0, 0);                        // empty store
    push_pose(500, 0, 0, 100);
    push_pose(1000, 0, 0, 200);                   // exactly on the keyframe threshold
    push_pose(1001, 0, 0, 300);
    push_pose(3000, 0, 0, 20301);                 // gap just over the minimum
    push_pose(3000, 2000, 0, 40301);              // gap equal to the minimum on one entry
    push_pose(3000, 7000, 0, 60000);              // exactly on the loop radius
    push_pose(20000, 3000, 0, 100000);
    push_pose(20000, -3000, 0, 100050);
    push_pose(20000, 0, 0, 200000);               // two candidates at equal distance
    push_pose(20000, 0, 2500, 5);                 // stamp going backwards
    push_pose(20000, 0, 2600, 6);
    push_pose(-8388608, 8388607, -8388608, 32'hFFFF_FFFF);
    push_pose(8388607, -8388608, 8388607, 32'hFFFF_FFFF);
    push_pose(8388607, -8388608, 8388607, 0);
    push_pose(-8388608, 8388607, -8388608, 32'h7FFF_FFFF);
    push_pose(-8386000, 8388607, -8388608, 32'hFFFF_FFFF);
    push_pose(-8386000, 8388607, -8388608, 32'h8000_0000);
    drain();

    repeat (100) push_walk(1500, 3000, 15, 8);
    drain();

    // upper bits of the 23-bit registers must be dropped
    write_reg(CFG_KF_DIST, 32'hFF80_0000);
    write_reg(CFG_LOOP_RAD, 32'hFFFF_FFFF);
    write_reg(CFG_LOOP_GAP, '0);
    repeat (80) push_walk(400, 200, 10, 5);
    drain();

    write_reg(CFG_KF_DIST, 32'd8388607);
    write_reg(CFG_LOOP_RAD, '0);
    write_reg(CFG_LOOP_GAP, 32'hFFFF_FFFF);
    repeat (50) push_walk(6000000, 100000, 10, 30);
    drain();

    write_reg(CFG_KF_DIST, $urandom_range(100, 3000));
    write_reg(CFG_LOOP_RAD, $urandom_range(1000, 60000));
    write_reg(CFG_LOOP_GAP, $urandom_range(0, 100000));
    write_reg(CFG_SPARE, $urandom());
    repeat (120) push_walk(2000, 5000, 20, 8);
    drain();

    write_reg(CFG_KF_DIST, 32'd500);
    write_reg(CFG_LOOP_RAD, 32'd20000);
    write_reg(CFG_LOOP_GAP, 32'd1000);
    repeat (120) push_walk(800, 1000, 25, 5);
    drain();

    // any move becomes a keyframe, so the store keeps growing
    write_reg(CFG_KF_DIST, '0);
    write_reg(CFG_LOOP_RAD, 32'd25000);
    write_reg(CFG_LOOP_GAP, 32'd2000);
    repeat (70) push_walk(300, 500, 20, 3);
    drain();
    repeat (24) push_walk(300, 500, 20, 3);
    drain();

    repeat (40) @(negedge clk_i);
    if (bad_outcomes == 0 && outcomes_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Pose driver: bursts of requests with random idle stretches between them.
  int burst_left = 8;
  int idle_left  = 0;

  always @(posedge clk_i) begin
    logic offer;
    if (rst_ni) begin
      offer = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        outcomes_due.insert(outcomes_due.size(), search_outcome(poses_to_send.pop_front()));
        offer = 1'b0;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          idle_left  = ($urandom_range(1) == 0) ? 0 : $urandom_range(1, 20);
        end
      end
      if (!offer) begin
        if (idle_left > 0) idle_left--;
        else offer = (poses_to_send.size() != 0);
      end
      s_axis_tvalid <= offer;
      if (offer) s_axis_tdata <= poses_to_send[0];
    end
  end

  // Result side backpressure, with a long hold-off every few hundred results.
  rx_mode_e rx_mode   = RX_OPEN;
  int       mode_left = 0;
  int       hold_left = 0;
  int       hold_at   = 30;
  int       taken     = 0;

  always @(posedge clk_i) begin
    logic ready;
    int   pick;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) taken++;
      if (mode_left == 0) begin
        mode_left = 64;
        pick = $urandom_range(3);
        rx_mode = (pick == 1) ? RX_RANDOM : (pick == 2) ? RX_SPARSE : RX_OPEN;
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        ready = 1'b0;
      end else if (taken >= hold_at) begin
        hold_left = 400;
        hold_at += 300;
        ready = 1'b0;
      end else begin
        case (rx_mode)
          RX_RANDOM: ready = ($urandom_range(99) < 60);
          RX_SPARSE: ready = (mode_left % 3 == 0);
          default:   ready = 1'b1;
        endcase
      end
      m_axis_tready <= ready;
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    outcome_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(outcome_t)-1:0];
      checked++;
      if (outcomes_due.size() == 0) begin
        bad_outcomes++;
        if (bad_outcomes <= 10)
          $display("result %0d arrived with nothing outstanding: %h", checked, got);
      end else begin
        want = outcomes_due.pop_front();
        if (got.became_keyframe != want.became_keyframe ||
            got.keyframe_slot != want.keyframe_slot ||
            got.loop_found != want.loop_found ||
            got.loop_slot != want.loop_slot ||
            got.store_full != want.store_full) begin
          bad_outcomes++;
          if (bad_outcomes <= 10)
            $display("result %0d: exp kf=%0b slot=%0d loop=%0b lslot=%0d full=%0b, got kf=%0b slot=%0d loop=%0b lslot=%0d full=%0b",
                     checked, want.became_keyframe, want.keyframe_slot, want.loop_found,
                     want.loop_slot, want.store_full, got.became_keyframe,
                     got.keyframe_slot, got.loop_found, got.loop_slot, got.store_full);
        end
      end
    end
  end

endmodule
